// File: sv/akd_pkg.sv
// Package for the ADC ladder keypad decoder: shared types, widths and codes.
// Used by the front classifier, the item queue, the back end and the top level.
package akd_pkg;

  localparam int unsigned ThrW     = 10;
  localparam int unsigned ThrCount = 8;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned TolW     = 10;
  localparam int unsigned VoteW    = 4;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned LvlCntW  = 4;
  localparam int unsigned LvlW     = 3;
  localparam int unsigned WinW     = 4;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = 1;
  localparam int unsigned QCntW    = 2;

  localparam logic [VoteW-1:0] VoteMax = '1;
  localparam logic [HoldW-1:0] HoldMax = '1;

  localparam logic [LvlCntW-1:0]          RstLevelCount = 4'd4;
  localparam logic [ThrW*4-1:0]           RstThrLow     = 40'd962746256516;
  localparam logic [ThrW*4-1:0]           RstThrHigh    = 40'd0;
  localparam logic [CodeW*ThrCount-1:0]   RstKeyCodes   = 64'd18446744070924928838;
  localparam logic [TolW-1:0]             RstTolerance  = 10'd255;
  localparam logic [VoteW-1:0]            RstVoteLimit  = 4'd9;
  localparam logic [CodeW-1:0]            RstHoldKey    = 8'h46;
  localparam logic [HoldW-1:0]            RstHoldTicks  = 16'd2000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLevelCount = 4'd0,
    CfgThrLow     = 4'd1,
    CfgThrHigh    = 4'd2,
    CfgKeyCodes   = 4'd3,
    CfgTolerance  = 4'd4,
    CfgVoteLimit  = 4'd5,
    CfgHoldKey    = 4'd6,
    CfgHoldTicks  = 4'd7
  } cfg_idx_e;

  typedef enum logic {
    CmdSample = 1'b0,
    CmdTick   = 1'b1
  } cmd_e;

  // Settings the front classifier needs.
  typedef struct packed {
    logic [LvlCntW-1:0]       level_count;
    logic [ThrW*ThrCount-1:0] thresholds;  // level 0 in the low bits
    logic [TolW-1:0]          tolerance;
  } match_cfg_t;

  // Settings the back end needs.
  typedef struct packed {
    logic [LvlCntW-1:0]        level_count;
    logic [CodeW*ThrCount-1:0] key_codes;
    logic [VoteW-1:0]          vote_limit;
    logic [CodeW-1:0]          hold_key;
    logic [HoldW-1:0]          hold_ticks;
  } decide_cfg_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic            tick;
    logic            hit;
    logic [LvlW-1:0] lvl;
  } entry_t;

endpackage

// File: sv/akd_front.sv
// Front classifier: takes input items and matches samples against the ladder.
// Depends on akd_pkg; feeds akd_queue.
module akd_front #(
  parameter int unsigned MAX_LEVELS  = 8,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                    in_valid_i,
  input  logic                    cmd_i,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  input  akd_pkg::match_cfg_t     cfg_i,
  input  logic                    q_full_i,
  output logic                    in_stall_o,
  output logic                    push_o,
  output akd_pkg::entry_t         entry_o
);
  import akd_pkg::*;

  localparam int unsigned CmpW = (SAMPLE_BITS > ThrW) ? SAMPLE_BITS : ThrW;

  logic [LvlCntW-1:0] n_levels;
  logic [CmpW-1:0]    smp;
  logic [CmpW-1:0]    tol;
  logic [CmpW-1:0]    thr   [MAX_LEVELS];
  logic               match [MAX_LEVELS];
  logic               hit;
  logic [LvlW-1:0]    lvl;

  assign n_levels = (cfg_i.level_count > LvlCntW'(MAX_LEVELS)) ?
                    LvlCntW'(MAX_LEVELS) : cfg_i.level_count;
  assign smp = CmpW'(sample_i);
  assign tol = CmpW'(cfg_i.tolerance);

  // Compare every enabled level in parallel.
  always_comb begin
    for (int i = 0; i < MAX_LEVELS; i++) begin
      thr[i]   = CmpW'(cfg_i.thresholds[i*ThrW +: ThrW]);
      match[i] = (LvlCntW'(i) < n_levels) && (smp < thr[i]) && ((thr[i] - smp) <= tol);
    end
  end

  // Take the lowest matching level.
  always_comb begin
    hit = 1'b0;
    lvl = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (!hit && match[i]) begin
        hit = 1'b1;
        lvl = LvlW'(i);
      end
    end
  end

  assign in_stall_o    = q_full_i;
  assign push_o        = in_valid_i && !q_full_i;
  assign entry_o.tick  = (cmd_i == CmdTick);
  assign entry_o.hit   = (cmd_i == CmdSample) && hit;
  assign entry_o.lvl   = lvl;

endmodule

// File: sv/akd_queue.sv
// Two-entry queue of classified items between the front and the back end.
// Depends on akd_pkg.
module akd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  akd_pkg::entry_t entry_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output akd_pkg::entry_t entry_o
);
  import akd_pkg::*;

  entry_t            mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(push_i) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue push while full");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count out of range");

endmodule

// File: sv/akd_back.sv
// Back end: vote counters, window close, winner pick, hold timer, result register.
// Depends on akd_pkg; drains akd_queue.
module akd_back #(
  parameter int unsigned WINDOW_SAMPLES = 10,
  parameter int unsigned MAX_LEVELS     = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  akd_pkg::decide_cfg_t  cfg_i,
  input  logic                  q_valid_i,
  input  akd_pkg::entry_t       q_entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  key_valid_o,
  output logic [7:0]            key_code_o,
  output logic                  long_press_o
);
  import akd_pkg::*;

  logic [VoteW-1:0]   votes_q [MAX_LEVELS];
  logic [VoteW-1:0]   votes_d [MAX_LEVELS];
  logic [VoteW-1:0]   votes_nx [MAX_LEVELS];
  logic [WinW-1:0]    win_cnt_q, win_cnt_d;
  logic [HoldW-1:0]   elapsed_q, elapsed_d;
  logic               active_q, active_d;
  logic               out_valid_q, out_valid_d;
  logic               key_valid_q, key_valid_d;
  logic [CodeW-1:0]   key_code_q, key_code_d;
  logic               long_q, long_d;

  logic               take;
  logic               sample_item;
  logic               close;
  logic [LvlCntW-1:0] n_levels;
  logic               win;
  logic [CodeW-1:0]   win_code;
  logic [HoldW-1:0]   elapsed_base;

  assign pop_o       = q_valid_i && (!out_valid_q || !out_stall_i);
  assign take        = pop_o;
  assign sample_item = take && !q_entry_i.tick;
  assign close       = sample_item && (win_cnt_q == WinW'(WINDOW_SAMPLES - 1));
  assign n_levels    = (cfg_i.level_count > LvlCntW'(MAX_LEVELS)) ?
                       LvlCntW'(MAX_LEVELS) : cfg_i.level_count;

  // Votes after this sample, saturating.
  always_comb begin
    for (int i = 0; i < MAX_LEVELS; i++) begin
      votes_nx[i] = votes_q[i];
      if (q_entry_i.hit && (q_entry_i.lvl == LvlW'(i)) && (votes_q[i] != VoteMax)) begin
        votes_nx[i] = votes_q[i] + 1'b1;
      end
    end
  end

  // First enabled level over the limit wins.
  always_comb begin
    win      = 1'b0;
    win_code = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (!win && (LvlCntW'(i) < n_levels) && (votes_nx[i] > cfg_i.vote_limit)) begin
        win      = 1'b1;
        win_code = cfg_i.key_codes[i*CodeW +: CodeW];
      end
    end
  end

  assign elapsed_base = active_q ? elapsed_q : '0;

  always_comb begin
    votes_d     = votes_q;
    win_cnt_d   = win_cnt_q;
    elapsed_d   = elapsed_q;
    active_d    = active_q;
    out_valid_d = out_valid_q && out_stall_i;
    key_valid_d = key_valid_q;
    key_code_d  = key_code_q;
    long_d      = long_q;

    if (take && q_entry_i.tick) begin
      if (active_q && (elapsed_q != HoldMax)) begin
        elapsed_d = elapsed_q + 1'b1;
      end
    end

    if (sample_item) begin
      if (close) begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
          votes_d[i] = '0;
        end
        win_cnt_d   = '0;
        out_valid_d = 1'b1;
        key_valid_d = win;
        key_code_d  = win_code;
        if (win && (win_code == cfg_i.hold_key)) begin
          active_d  = 1'b1;
          elapsed_d = elapsed_base;
          long_d    = (elapsed_base >= cfg_i.hold_ticks);
        end else begin
          active_d  = 1'b0;
          elapsed_d = '0;
          long_d    = 1'b0;
        end
      end else begin
        votes_d   = votes_nx;
        win_cnt_d = win_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        votes_q[i] <= '0;
      end
      win_cnt_q   <= '0;
      elapsed_q   <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      votes_q     <= votes_d;
      win_cnt_q   <= win_cnt_d;
      elapsed_q   <= elapsed_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_valid_q <= key_valid_d;
    key_code_q  <= key_code_d;
    long_q      <= long_d;
  end

  assign out_valid_o  = out_valid_q;
  assign key_valid_o  = key_valid_q;
  assign key_code_o   = key_code_q;
  assign long_press_o = long_q;

  a_win_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_cnt_q < WinW'(WINDOW_SAMPLES))
    else $error("window count past window length");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close |=> (win_cnt_q == '0) && (votes_q[0] == '0))
    else $error("window close did not clear votes");

  a_idle_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (elapsed_q == '0))
    else $error("hold timer nonzero while stopped");

  a_no_result_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop_o)
    else $error("item taken while result stalled");

endmodule

// File: sv/adc_ladder_keypad_decoder.sv
// Top level of the ADC ladder keypad decoder: config registers and wiring.
// Depends on akd_pkg, akd_front, akd_queue and akd_back.
// Path: a window's last sample goes through one queue stage, then the result register.
// Throughput: one item per cycle unless the queue is full; the back end drains one queue entry
// a cycle unless a pending result is held by out_stall_i.
// Reset: config registers take their defaults, votes, window count and timer clear.
module adc_ladder_keypad_decoder #(
  parameter int unsigned WINDOW_SAMPLES = 10,
  parameter int unsigned MAX_LEVELS     = 8,
  parameter int unsigned SAMPLE_BITS    = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         key_valid_o,
  output logic [7:0]                   key_code_o,
  output logic                         long_press_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [akd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [akd_pkg::CfgDataW-1:0] cfg_data_i
);
  import akd_pkg::*;

  // Configuration registers.
  logic [LvlCntW-1:0]        level_count_q;
  logic [ThrW*4-1:0]         thr_low_q;
  logic [ThrW*4-1:0]         thr_high_q;
  logic [CodeW*ThrCount-1:0] key_codes_q;
  logic [TolW-1:0]           tolerance_q;
  logic [VoteW-1:0]          vote_limit_q;
  logic [CodeW-1:0]          hold_key_q;
  logic [HoldW-1:0]          hold_ticks_q;
  logic                      cfg_we;

  match_cfg_t  match_cfg;
  decide_cfg_t decide_cfg;
  entry_t      push_entry;
  entry_t      pop_entry;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_valid;

  // Writes are always taken; an unknown index is dropped.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= RstLevelCount;
      thr_low_q     <= RstThrLow;
      thr_high_q    <= RstThrHigh;
      key_codes_q   <= RstKeyCodes;
      tolerance_q   <= RstTolerance;
      vote_limit_q  <= RstVoteLimit;
      hold_key_q    <= RstHoldKey;
      hold_ticks_q  <= RstHoldTicks;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgLevelCount: level_count_q <= cfg_data_i[LvlCntW-1:0];
        CfgThrLow:     thr_low_q     <= cfg_data_i[ThrW*4-1:0];
        CfgThrHigh:    thr_high_q    <= cfg_data_i[ThrW*4-1:0];
        CfgKeyCodes:   key_codes_q   <= cfg_data_i;
        CfgTolerance:  tolerance_q   <= cfg_data_i[TolW-1:0];
        CfgVoteLimit:  vote_limit_q  <= cfg_data_i[VoteW-1:0];
        CfgHoldKey:    hold_key_q    <= cfg_data_i[CodeW-1:0];
        CfgHoldTicks:  hold_ticks_q  <= cfg_data_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  assign match_cfg.level_count = level_count_q;
  assign match_cfg.thresholds  = {thr_high_q, thr_low_q};
  assign match_cfg.tolerance   = tolerance_q;

  assign decide_cfg.level_count = level_count_q;
  assign decide_cfg.key_codes   = key_codes_q;
  assign decide_cfg.vote_limit  = vote_limit_q;
  assign decide_cfg.hold_key    = hold_key_q;
  assign decide_cfg.hold_ticks  = hold_ticks_q;

  // Front: classify each sample to its ladder level as it is accepted.
  akd_front #(
    .MAX_LEVELS  (MAX_LEVELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .sample_i   (sample_i),
    .cfg_i      (match_cfg),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Queue: decouple input stalls from output stalls.
  akd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  // Back: vote, close the window, pick the winner, time the hold key.
  akd_back #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES),
    .MAX_LEVELS     (MAX_LEVELS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (decide_cfg),
    .q_valid_i    (q_valid),
    .q_entry_i    (pop_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_valid_o  (key_valid_o),
    .key_code_o   (key_code_o),
    .long_press_o (long_press_o)
  );

endmodule
